FILE: rtl/dare_pkg.sv
// ----------------------------------------------------------------------------
// dare_pkg
// Shared widths, constants and types for the drum attack/release envelope:
// table geometry, phase format and the table bank write port.
// ----------------------------------------------------------------------------
package dare_pkg;

    // Exponential table geometry (power of two, 256 .. 65536 words)
    localparam int TABLE_DEPTH = 4096;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int TBL_BW      = TBL_AW - 1;
    localparam int WORD_W      = 31;

    // Item field widths
    localparam int IDX_FIELD_W = 12;

    // 12.16 phase, top value 4094.0 fits in 28 bits
    localparam int PHASE_W = 28;
    localparam int FRAC_W  = 16;
    localparam logic [PHASE_W-1:0] ATTACK_STEP = PHASE_W'(65535 << 5);
    localparam logic [PHASE_W-1:0] PHASE_TOP   = PHASE_W'(4094 << 16);

    // Release decrement is the table word shifted right by 8
    localparam int DEC_SHIFT = 8;
    localparam int DEC_W     = WORD_W - DEC_SHIFT;

    // Result width
    localparam int ENV_W = 15;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [TBL_BW-1:0] t_bank_addr;

    // Write port of one table bank
    typedef struct packed {
        logic       we;
        t_bank_addr addr;
        t_word      data;
    } t_tbl_wr;

    // Reduce a 12-bit index field to a table address (modulo the depth)
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [IDX_FIELD_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[TBL_AW-1:0];
    endfunction

endpackage

FILE: rtl/drum_attack_release_envelope.sv
// ----------------------------------------------------------------------------
// drum_attack_release_envelope
// Attack/release envelope over an exponential table: one sample item gives
// one interpolated level and the stage; a table item writes one word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ----------------------------------
//  s        in         i_s_tvalid / o_s_tready  tdata: trigger_level, release_time,
//                                               table_index, table_word; tuser: func
//  m        out        o_m_tvalid / i_m_tready  tdata: envelope, stage
//
//  One item per cycle while o_s_tready is high. A sample item passes the r1, r2,
//  r3 and r4 registers into the result queue; a table write completes at its accept edge.
//  The table sits in even/odd banks, each with two read ports: one reads the
//  release word at accept, the other the interpolation pair in the cycle after,
//  when the phase and stage registers update.
//  Reset clears phase, stage, pipeline valids and the result queue; the table
//  is not cleared.
//  Up to eight sample items may be outstanding; o_s_tready drops after that
//  until results are taken.
//
module drum_attack_release_envelope (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] trigger_level, [12:1] release_time, [24:13] table_index,
    // [55:25] table_word
    input  logic [55:0] i_s_tdata,
    // [0] func
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [14:0] envelope, [16:15] stage, [23:17] zero
    output logic [23:0] o_m_tdata
);
    import dare_pkg::*;

    typedef enum logic [1:0] {
        ST_REST    = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_RELEASE = 2'd2
    } t_stage;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        t_stage             stage;
        logic [ENV_W-1:0]   env;
    } t_res;

    // ------------------------------------------------------------------
    // Input unpack and accept
    // ------------------------------------------------------------------
    logic                  in_func;
    logic                  in_trig_level;
    logic [IDX_FIELD_W-1:0] in_rel_time;
    logic [IDX_FIELD_W-1:0] in_tbl_index;
    t_word                 in_tbl_word;
    logic                  acc;
    logic                  acc_sample;
    logic                  acc_write;
    logic [TBL_AW-1:0]     rel_addr;
    logic [TBL_AW-1:0]     wr_addr;

    assign in_func       = i_s_tuser;
    assign in_trig_level = i_s_tdata[0];
    assign in_rel_time   = i_s_tdata[12:1];
    assign in_tbl_index  = i_s_tdata[24:13];
    assign in_tbl_word   = i_s_tdata[55:25];

    assign acc        = i_s_tvalid & o_s_tready;
    assign acc_sample = acc & ~in_func;
    assign acc_write  = acc & in_func;
    assign rel_addr   = tbl_addr(in_rel_time);
    assign wr_addr    = tbl_addr(in_tbl_index);

    // ------------------------------------------------------------------
    // Table banks: even words and odd words
    // ------------------------------------------------------------------
    t_tbl_wr    wr_even;
    t_tbl_wr    wr_odd;
    t_bank_addr ra_even_addr;
    t_bank_addr ra_odd_addr;
    t_word      ra_even_data;
    t_word      ra_odd_data;
    t_word      rb_even_data;
    t_word      rb_odd_data;

    assign wr_even = '{we: acc_write & ~wr_addr[0], addr: wr_addr[TBL_AW-1:1],
                       data: in_tbl_word};
    assign wr_odd  = '{we: acc_write & wr_addr[0], addr: wr_addr[TBL_AW-1:1],
                       data: in_tbl_word};

    dare_bank u_bank_even (
        .i_clk     (i_clk),
        .i_wr      (wr_even),
        .i_ra_addr (ra_even_addr),
        .o_ra_data (ra_even_data),
        .i_rb_addr (rel_addr[TBL_AW-1:1]),
        .o_rb_data (rb_even_data)
    );

    dare_bank u_bank_odd (
        .i_clk     (i_clk),
        .i_wr      (wr_odd),
        .i_ra_addr (ra_odd_addr),
        .o_ra_data (ra_odd_data),
        .i_rb_addr (rel_addr[TBL_AW-1:1]),
        .o_rb_data (rb_odd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: release word available, update phase and stage
    // ------------------------------------------------------------------
    logic               r1_valid;
    logic               r1_trig;
    logic               r1_relpar;
    t_stage             r_stage;
    logic [PHASE_W-1:0] r_phase;
    t_stage             n_stage;
    logic [PHASE_W-1:0] n_phase;
    t_word              rel_word;
    logic [DEC_W-1:0]   rel_dec;
    logic [PHASE_W:0]   att_sum;
    logic [PHASE_W:0]   rel_diff;
    logic [TBL_AW-1:0]  idx;
    t_bank_addr         idx_half;

    // Capture sample control at accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= acc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_trig   <= ~in_trig_level;
        r1_relpar <= rel_addr[0];
    end

    // Next phase and stage
    always_comb begin
        rel_word = r1_relpar ? rb_odd_data : rb_even_data;
        rel_dec  = rel_word[WORD_W-1:DEC_SHIFT];
        att_sum  = {1'b0, r_phase} + {1'b0, ATTACK_STEP};
        rel_diff = {1'b0, r_phase} - (PHASE_W+1)'(rel_dec);
        n_phase  = r_phase;
        n_stage  = r_stage;
        unique case (r_stage)
            ST_ATTACK: begin
                if (att_sum >= {1'b0, PHASE_TOP}) begin
                    n_phase = PHASE_TOP;
                    n_stage = ST_RELEASE;
                end else begin
                    n_phase = att_sum[PHASE_W-1:0];
                end
            end
            ST_RELEASE: begin
                n_phase = rel_diff[PHASE_W] ? '0 : rel_diff[PHASE_W-1:0];
                if (r1_trig) begin
                    n_stage = ST_ATTACK;
                end else if (rel_diff[PHASE_W]) begin
                    n_stage = ST_REST;
                end
            end
            default: begin
                n_stage = r1_trig ? ST_ATTACK : ST_REST;
            end
        endcase
    end

    // Hold phase and stage; advance on each sample item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_REST;
            r_phase <= '0;
        end else if (r1_valid) begin
            r_stage <= n_stage;
            r_phase <= n_phase;
        end
    end

    // Interpolation pair addresses from the new phase
    always_comb begin
        idx          = tbl_addr(n_phase[PHASE_W-1:FRAC_W]);
        idx_half     = idx[TBL_AW-1:1];
        ra_odd_addr  = idx_half;
        ra_even_addr = idx[0] ? idx_half + 1'b1 : idx_half;
    end

    // ------------------------------------------------------------------
    // Stage 2: pick low and high words, form their difference
    // ------------------------------------------------------------------
    logic              r2_valid;
    logic              r2_zero;
    t_stage            r2_stage;
    logic              r2_par;
    logic [FRAC_W-1:0] r2_frac;
    t_word             lo_word;
    t_word             hi_word;
    logic signed [WORD_W:0] word_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_zero  <= (r_stage == ST_REST);
        r2_stage <= n_stage;
        r2_par   <= idx[0];
        r2_frac  <= n_phase[FRAC_W-1:0];
    end

    always_comb begin
        lo_word   = r2_par ? ra_odd_data : ra_even_data;
        hi_word   = r2_par ? ra_even_data : ra_odd_data;
        word_diff = $signed({1'b0, hi_word}) - $signed({1'b0, lo_word});
    end

    // ------------------------------------------------------------------
    // Stage 3: multiply the difference by the fraction
    // ------------------------------------------------------------------
    localparam int PROD_W = WORD_W + 1 + FRAC_W + 1;

    logic                     r3_valid;
    logic                     r3_zero;
    t_stage                   r3_stage;
    t_word                    r3_lo;
    logic signed [WORD_W:0]   r3_diff;
    logic [FRAC_W-1:0]        r3_frac;
    logic signed [FRAC_W:0]   frac_s;
    logic signed [PROD_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_zero  <= r2_zero;
        r3_stage <= r2_stage;
        r3_lo    <= lo_word;
        r3_diff  <= word_diff;
        r3_frac  <= r2_frac;
    end

    always_comb begin
        frac_s = $signed({1'b0, r3_frac});
        prod   = r3_diff * frac_s;
    end

    // ------------------------------------------------------------------
    // Stage 4: add the scaled low word, take the level
    // ------------------------------------------------------------------
    logic                     r4_valid;
    logic                     r4_zero;
    t_stage                   r4_stage;
    t_word                    r4_lo;
    logic signed [PROD_W-1:0] r4_prod;
    logic signed [PROD_W-1:0] mix;
    t_res                     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_zero  <= r3_zero;
        r4_stage <= r3_stage;
        r4_lo    <= r3_lo;
        r4_prod  <= prod;
    end

    always_comb begin
        mix       = $signed({2'b00, r4_lo, {FRAC_W{1'b0}}}) + r4_prod;
        res.stage = r4_stage;
        res.env   = r4_zero ? '0 : mix[2*FRAC_W+ENV_W-1:2*FRAC_W];
    end

    // ------------------------------------------------------------------
    // Result queue and outstanding count
    // ------------------------------------------------------------------
    t_res               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_CW-1:0] r_fcount;
    logic [FIFO_CW-1:0] r_outst;
    logic               pop;
    t_res               head;

    assign pop = o_m_tvalid & i_m_tready;

    // Store each finished item
    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r_fifo[r_wp] <= res;
        end
    end

    // Advance pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_fcount <= '0;
            r_outst  <= '0;
        end else begin
            if (r4_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fcount <= r_fcount + FIFO_CW'(r4_valid) - FIFO_CW'(pop);
            r_outst  <= r_outst + FIFO_CW'(acc_sample) - FIFO_CW'(pop);
        end
    end

    assign head       = r_fifo[r_rp];
    assign o_m_tvalid = (r_fcount != '0);
    assign o_m_tdata  = {7'd0, head.stage, head.env};
    assign o_s_tready = (r_outst < FIFO_CW'(FIFO_DEPTH));

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcount <= r_outst)
        else $error("result queue holds more items than are outstanding");

    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= FIFO_CW'(FIFO_DEPTH))
        else $error("outstanding count exceeds queue depth");

    a_rest_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ST_REST) |-> (r_phase == '0))
        else $error("phase not zero at rest");

    a_phase_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_TOP)
        else $error("phase above top");

endmodule

FILE: rtl/dare_bank.sv
// ----------------------------------------------------------------------------
// dare_bank
// One half of the exponential table (even or odd words). One write port and
// two read ports, read data registered, old data returned on a same-address
// read and write.
// ----------------------------------------------------------------------------
module dare_bank (
    input  logic                i_clk,
    input  dare_pkg::t_tbl_wr   i_wr,
    input  dare_pkg::t_bank_addr i_ra_addr,
    output dare_pkg::t_word     o_ra_data,
    input  dare_pkg::t_bank_addr i_rb_addr,
    output dare_pkg::t_word     o_rb_data
);
    import dare_pkg::*;

    t_word r_mem [TABLE_DEPTH/2];
    t_word r_ra_data;
    t_word r_rb_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read both ports every cycle
    always_ff @(posedge i_clk) begin
        r_ra_data <= r_mem[i_ra_addr];
        r_rb_data <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule

FILE: tb/drum_attack_release_envelope_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_attack_release_envelope_tb
// Self-checking bench for the attack/release envelope. Table words are loaded
// on demand, just before the first sample item that reads them. Short
// hand-picked sample items come first, then a random run. Trigger odds in the
// random run depend on the tracked stage, so the run passes through attacks,
// releases and retriggers at the end of release. Every accepted item updates
// a local copy of the envelope state. Each result is compared field by field
// with the oldest level due.
// ----------------------------------------------------------------------------
module drum_attack_release_envelope_tb;
    import dare_pkg::*;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_WRITE   = 1'b1;
    localparam int   TOTAL_ITEMS  = 650;
    localparam int   BURST_LO     = 200;
    localparam int   BURST_HI     = 400;
    localparam int   SETTLE_CYC   = 40;
    localparam int   CYCLE_LIMIT  = 400_000;
    // Table words at the top of the table are loaded large for fast releases
    localparam int   FAST_LO      = 4080;

    typedef enum logic [1:0] {
        STAGE_REST    = 2'd0,
        STAGE_ATTACK  = 2'd1,
        STAGE_RELEASE = 2'd2
    } t_env_stage;

    // One input item, packed exactly as i_s_tdata
    typedef struct packed {
        logic [WORD_W-1:0]      word;
        logic [IDX_FIELD_W-1:0] index;
        logic [IDX_FIELD_W-1:0] rtime;
        logic                   trig_level;
    } t_env_item;

    typedef struct {
        logic [ENV_W-1:0] level;
        t_env_stage       stage;
    } t_env_level;

    // Track table, phase and stage; hold the levels still due from the block
    class envelope_tracker;
        t_word              words [TABLE_DEPTH];
        bit                 written [TABLE_DEPTH];
        logic [PHASE_W-1:0] phase;
        t_env_stage         stage;
        t_env_level         levels_due [$];
        int                 errors;

        function new();
            phase  = '0;
            stage  = STAGE_REST;
            errors = 0;
        endfunction

        function logic [DEC_W-1:0] decrement(logic [IDX_FIELD_W-1:0] rtime);
            return DEC_W'(words[rtime] >> DEC_SHIFT);
        endfunction

        // True when a sample with this release index ends the release
        function bit release_ends(logic [IDX_FIELD_W-1:0] rtime);
            return stage == STAGE_RELEASE &&
                   ({1'b0, phase} < (PHASE_W+1)'(decrement(rtime)));
        endfunction

        // Phase after one sample with this release index; state is kept
        function logic [PHASE_W-1:0] phase_after(logic [IDX_FIELD_W-1:0] rtime);
            logic [PHASE_W:0]   sum;
            logic [PHASE_W-1:0] ph;
            ph = phase;
            case (stage)
                STAGE_ATTACK: begin
                    sum = {1'b0, phase} + {1'b0, ATTACK_STEP};
                    ph  = (sum >= {1'b0, PHASE_TOP}) ? PHASE_TOP : sum[PHASE_W-1:0];
                end
                STAGE_RELEASE: begin
                    sum = {1'b0, phase} - (PHASE_W+1)'(decrement(rtime));
                    ph  = sum[PHASE_W] ? '0 : sum[PHASE_W-1:0];
                end
                default: begin
                    ph = phase;
                end
            endcase
            return ph;
        endfunction

        // Interpolate two neighboring words at the current phase
        function logic [ENV_W-1:0] level_at();
            logic [TBL_AW-1:0] lo_i;
            logic [TBL_AW-1:0] hi_i;
            logic [63:0]       frac;
            logic [63:0]       mix;
            lo_i = phase[PHASE_W-1:FRAC_W];
            hi_i = lo_i + 1'b1;
            frac = 64'(phase[FRAC_W-1:0]);
            mix  = 64'(words[lo_i]) * (64'd65536 - frac) + 64'(words[hi_i]) * frac;
            return mix[32 +: ENV_W];
        endfunction

        // Advance the envelope by one accepted item
        function void apply_item(logic func, t_env_item item);
            logic             trig;
            logic             ended;
            logic [PHASE_W:0] acc;
            t_env_level       due;
            if (func == FUNC_WRITE) begin
                words[item.index]   = item.word;
                written[item.index] = 1'b1;
                return;
            end
            trig = (item.trig_level == 1'b0);
            case (stage)
                STAGE_ATTACK: begin
                    acc = {1'b0, phase} + {1'b0, ATTACK_STEP};
                    if (acc >= {1'b0, PHASE_TOP}) begin
                        phase = PHASE_TOP;
                        stage = STAGE_RELEASE;
                    end else begin
                        phase = acc[PHASE_W-1:0];
                    end
                    due.level = level_at();
                end
                STAGE_RELEASE: begin
                    acc   = {1'b0, phase} - (PHASE_W+1)'(decrement(item.rtime));
                    ended = acc[PHASE_W];
                    phase = ended ? '0 : acc[PHASE_W-1:0];
                    // A retrigger wins over the end of release
                    if (trig) begin
                        stage = STAGE_ATTACK;
                    end else if (ended) begin
                        stage = STAGE_REST;
                    end
                    due.level = level_at();
                end
                default: begin
                    stage     = trig ? STAGE_ATTACK : STAGE_REST;
                    due.level = '0;
                end
            endcase
            due.stage = stage;
            levels_due.push_back(due);
        endfunction

        // Compare one accepted result with the oldest level due
        function void check_level(logic [23:0] data);
            t_env_level due;
            if (levels_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual 0x%06h",
                         $time, data);
                errors++;
                return;
            end
            due = levels_due.pop_front();
            if (data[ENV_W-1:0] !== due.level) begin
                $display("%0t: envelope mismatch, expected %0d, actual %0d",
                         $time, due.level, data[ENV_W-1:0]);
                errors++;
            end
            if (data[ENV_W+1:ENV_W] !== due.stage) begin
                $display("%0t: stage mismatch, expected %0d, actual %0d",
                         $time, due.stage, data[ENV_W+1:ENV_W]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // [0] trigger_level, [12:1] release_time, [24:13] table_index,
    // [55:25] table_word
    logic [55:0] i_s_tdata   = '0;
    // [0] func
    logic        i_s_tuser   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // [14:0] envelope, [16:15] stage, [23:17] zero
    logic [23:0] o_m_tdata;

    envelope_tracker tracker;
    int              src_idle_pct = 20;
    int              snk_idle_pct = 20;
    int              cycle_count  = 0;
    int              items_sent   = 0;

    drum_attack_release_envelope DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_level(o_m_tdata);
        end
    end

    // Large words at the top of the table, spread-out words below
    function automatic t_word pick_word(input logic [IDX_FIELD_W-1:0] index);
        if (int'(index) >= FAST_LO) begin
            return {1'b1, 30'($urandom)};
        end
        return WORD_W'($urandom) >> $urandom_range(0, 12);
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input logic func, input t_env_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= item;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        tracker.apply_item(func, item);
        items_sent++;
    endtask

    task automatic load_word(input logic [IDX_FIELD_W-1:0] index, input t_word word);
        t_env_item item;
        item.word       = word;
        item.index      = index;
        item.rtime      = IDX_FIELD_W'($urandom);
        item.trig_level = 1'($urandom);
        send_item(FUNC_WRITE, item);
    endtask

    // Load a table word unless it already holds one
    task automatic ensure_word(input logic [IDX_FIELD_W-1:0] index);
        if (!tracker.written[index]) begin
            load_word(index, pick_word(index));
        end
    endtask

    // Load the words the next sample reads, then send the sample
    task automatic play_sample(input logic trig_level,
                               input logic [IDX_FIELD_W-1:0] rtime);
        t_env_item          item;
        logic [PHASE_W-1:0] ph;
        logic [TBL_AW-1:0]  lo_i;
        if (tracker.stage == STAGE_RELEASE) begin
            ensure_word(rtime);
        end
        if (tracker.stage != STAGE_REST) begin
            ph   = tracker.phase_after(rtime);
            lo_i = ph[PHASE_W-1:FRAC_W];
            ensure_word(IDX_FIELD_W'(lo_i));
            ensure_word(IDX_FIELD_W'(lo_i + 1'b1));
        end
        item.word       = WORD_W'($urandom);
        item.index      = IDX_FIELD_W'($urandom);
        item.rtime      = rtime;
        item.trig_level = trig_level;
        send_item(FUNC_SAMPLE, item);
    endtask

    task automatic wait_drained();
        while (tracker.levels_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [IDX_FIELD_W-1:0] rtime;
        bit                     fire;

        tracker = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme words, then rest, start of attack and trigger in attack
        load_word('0, '0);
        load_word('1, '1);
        load_word(12'hAAA, 31'h2AAA_AAAA);
        load_word(12'h555, 31'h5555_5555);
        play_sample(1'b1, 12'h000);
        play_sample(1'b1, 12'hFFF);
        play_sample(1'b0, 12'hAAA);
        play_sample(1'b0, 12'h555);
        for (int i = 0; i < 6; i++) begin
            play_sample(1'b1, 12'hFFF);
        end

        // Hold off until every level due has come back
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_drained();

        // Random run; trigger odds follow the tracked stage
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= BURST_LO && items_sent < BURST_HI) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 20;
                snk_idle_pct = 20;
            end
            if ($urandom_range(99) < 8) begin
                load_word(IDX_FIELD_W'($urandom_range(0, FAST_LO - 1)), WORD_W'($urandom));
            end else begin
                if ($urandom_range(99) < 75) begin
                    rtime = IDX_FIELD_W'($urandom_range(FAST_LO, TABLE_DEPTH - 1));
                end else begin
                    rtime = IDX_FIELD_W'($urandom);
                end
                case (tracker.stage)
                    STAGE_REST:   fire = ($urandom_range(99) < 40);
                    STAGE_ATTACK: fire = ($urandom_range(99) < 5);
                    default: begin
                        ensure_word(rtime);
                        if (tracker.release_ends(rtime)) begin
                            fire = ($urandom_range(99) < 50);
                        end else begin
                            fire = ($urandom_range(99) < 3);
                        end
                    end
                endcase
                play_sample(~fire, rtime);
            end
        end

        // Drain and let the pipeline settle
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (tracker.levels_due.size() != 0) begin
            $display("%0t: levels left over, expected 0, actual %0d",
                     $time, tracker.levels_due.size());
            tracker.errors++;
        end

        if (tracker.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dare_pkg.sv
rtl/dare_bank.sv
rtl/drum_attack_release_envelope.sv
tb/drum_attack_release_envelope_tb.sv
